### rtl/core/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types and constants of the signal-strength record sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    typedef struct packed {
        logic [7:0]  strength;
        logic [7:0]  channel_no;
        logic [7:0]  security_kind;
        logic [47:0] station_addr;
        logic [5:0]  source_tag;
    } rec_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/core/rss_if.sv
// ----------------------------------------------------------------------------
// rss_in_if / rss_out_if
// Valid/ready channels for incoming scan records and sorted results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rss_in_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] strength;
    logic [7:0]        channel_no;
    logic [7:0]        security_kind;
    logic [47:0]       station_addr;
    logic [5:0]        source_tag;
    logic              final_record;

    modport source (
        output valid, strength, channel_no, security_kind, station_addr,
               source_tag, final_record,
        input  ready
    );
    modport sink (
        input  valid, strength, channel_no, security_kind, station_addr,
               source_tag, final_record,
        output ready
    );
endinterface

interface rss_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] out_strength;
    logic [7:0]        out_channel_no;
    logic [7:0]        out_security_kind;
    logic [47:0]       out_station_addr;
    logic [5:0]        out_source_tag;
    logic              out_last;

    modport source (
        output valid, out_strength, out_channel_no, out_security_kind,
               out_station_addr, out_source_tag, out_last,
        input  ready
    );
    modport sink (
        input  valid, out_strength, out_channel_no, out_security_kind,
               out_station_addr, out_source_tag, out_last,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/record_sort_by_signal_strength_unit.sv
// ----------------------------------------------------------------------------
// record_sort_by_signal_strength_unit
// Stable descending insertion sort of scan records on a row of compare cells.
// ----------------------------------------------------------------------------
// A record is accepted every cycle while no results are being drained.
// A record marked final is inserted in its cycle; results follow from the
// next cycle, one per cycle while the sink is ready, count_reg in all.
// No record is accepted until the last result is taken.
// Reset clears the held count and the drain flag; cell contents stay as is.
`default_nettype none

module record_sort_by_signal_strength_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rss_in_if.sink     records,
    rss_out_if.source  sorted
);
    import rss_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             drain_reg;
    logic             drain_next;
    logic             in_acc;
    logic             out_acc;
    cell_ctl_t        ctl;
    rec_t             new_rec;
    rec_t             cell_rec  [MAX_RECORDS];
    logic             cell_take [MAX_RECORDS];

    assign records.ready = !drain_reg;
    assign in_acc        = records.valid && records.ready;
    assign out_acc       = sorted.valid && sorted.ready;

    assign new_rec.strength      = records.strength;
    assign new_rec.channel_no    = records.channel_no;
    assign new_rec.security_kind = records.security_kind;
    assign new_rec.station_addr  = records.station_addr;
    assign new_rec.source_tag    = records.source_tag;

    assign ctl.insert = in_acc;
    assign ctl.shift  = out_acc;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RECORDS; gi++)
        begin : g_cell
            rss_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .new_rec   (new_rec),
                .occupied  (count_reg > CNT_W'(gi)),
                .prev_take ((gi == 0) ? 1'b0 : cell_take[(gi == 0) ? 0 : gi - 1]),
                .prev_rec  (cell_rec[(gi == 0) ? 0 : gi - 1]),
                .next_rec  (cell_rec[(gi == MAX_RECORDS - 1) ? gi : gi + 1]),
                .take      (cell_take[gi]),
                .rec       (cell_rec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        drain_next = drain_reg;
        if (in_acc)
        begin
            if (count_reg != CNT_W'(MAX_RECORDS))
            begin
                count_next = count_reg + CNT_W'(1);
            end
            drain_next = records.final_record;
        end
        else if (out_acc)
        begin
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                drain_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            drain_reg <= drain_next;
        end
    end

    assign sorted.valid             = drain_reg && (count_reg != '0);
    assign sorted.out_strength      = cell_rec[0].strength;
    assign sorted.out_channel_no    = cell_rec[0].channel_no;
    assign sorted.out_security_kind = cell_rec[0].security_kind;
    assign sorted.out_station_addr  = cell_rec[0].station_addr;
    assign sorted.out_source_tag    = cell_rec[0].source_tag;
    assign sorted.out_last          = (count_reg == CNT_W'(1));

endmodule

`default_nettype wire

### rtl/core/rss_cell.sv
// ----------------------------------------------------------------------------
// rss_cell
// One slot of the sorted store: compares the incoming record with its own,
// loads the new record or its left neighbor on insert, and takes its right
// neighbor when the store drains.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_cell (
    input  wire logic              clk,
    input  wire rss_pkg::cell_ctl_t ctl,
    input  wire rss_pkg::rec_t     new_rec,
    input  wire logic              occupied,
    input  wire logic              prev_take,
    input  wire rss_pkg::rec_t     prev_rec,
    input  wire rss_pkg::rec_t     next_rec,
    output logic                   take,
    output rss_pkg::rec_t          rec
);
    import rss_pkg::*;

    rec_t rec_reg;
    rec_t rec_next;

    // A new record goes ahead of a held one only when strictly stronger, so
    // equal keys keep their arrival order.
    assign take = !occupied || ($signed(new_rec.strength) > $signed(rec_reg.strength));
    assign rec  = rec_reg;

    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.insert && take)
        begin
            rec_next = prev_take ? prev_rec : new_rec;
        end
        else if (ctl.shift)
        begin
            rec_next = next_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

`default_nettype wire

### rtl/core/rss_checker.sv
// ----------------------------------------------------------------------------
// rss_checker
// Port-level checks of the record sorter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic in_final,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_last
);

    logic in_acc;
    logic out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Results and new records never share a cycle.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("result offered while input is open");

    // A final record always yields at least one result.
    a_final_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_final) |=> out_valid)
        else $error("final record produced no result");

    // Other records produce nothing.
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !in_final) |=> !out_valid)
        else $error("result without a final record");

    // A run continues until its last transaction.
    a_run_goes_on: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && !out_last) |=> out_valid)
        else $error("run ended before its last transaction");

    // After the last transaction the input reopens.
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && out_last) |=> (!out_valid && in_ready))
        else $error("run did not end after its last transaction");

endmodule

bind record_sort_by_signal_strength_unit rss_checker u_rss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (records.valid),
    .in_ready  (records.ready),
    .in_final  (records.final_record),
    .out_valid (sorted.valid),
    .out_ready (sorted.ready),
    .out_last  (sorted.out_last)
);

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the signal-strength record sorter. Sets of scan
// records are pushed through the input channel. A scoreboard keeps its own
// sorted copy of the held records, strongest first, with ties in arrival
// order and the weakest record dropped on overflow. It then checks every
// sorted transaction field by field. Both channels idle at random, and the
// sink holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rss_pkg::*;

    typedef struct packed {
        rec_t rec;
        logic last;
    } sorted_entry_t;

    class scan_order_board;
        rec_t          held[$];
        sorted_entry_t pending[$];
        int            errors;
        int            results_seen;

        function void note_record(rec_t r, bit fin);
            int            pos;
            sorted_entry_t e;
            pos = 0;
            while (pos < held.size() && $signed(held[pos].strength) >= $signed(r.strength))
                pos++;
            if (pos < MAX_RECORDS)
            begin
                held.insert(pos, r);
                if (held.size() > MAX_RECORDS)
                    held.delete(held.size() - 1);
            end
            if (fin)
            begin
                foreach (held[k])
                begin
                    e.rec  = held[k];
                    e.last = (k == held.size() - 1);
                    pending.push_back(e);
                end
                held.delete();
            end
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(rec_t got, bit got_last);
            sorted_entry_t want;
            results_seen++;
            if (pending.size() == 0)
            begin
                $error("Unexpected transaction: strength %0d, tag %0d",
                       $signed(got.strength), got.source_tag);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("out_strength", $signed(want.rec.strength), $signed(got.strength));
            compare_field("out_channel_no", want.rec.channel_no, got.channel_no);
            compare_field("out_security_kind", want.rec.security_kind, got.security_kind);
            compare_field("out_station_addr", want.rec.station_addr, got.station_addr);
            compare_field("out_source_tag", want.rec.source_tag, got.source_tag);
            compare_field("out_last", want.last, got_last);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   records_sent;
    bit   hold_done;

    scan_order_board board;

    rss_in_if  records();
    rss_out_if sorted();

    record_sort_by_signal_strength_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .records(records),
        .sorted (sorted)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400us;
        $display("tb: failure");
        $finish;
    end

    task automatic send_record(input rec_t r, input bit fin);
        bit calm;
        calm = (records_sent >= 70 && records_sent < 110);
        if (!calm && $urandom_range(99) < 13)
        begin
            records.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        records.valid         <= 1'b1;
        records.strength      <= r.strength;
        records.channel_no    <= r.channel_no;
        records.security_kind <= r.security_kind;
        records.station_addr  <= r.station_addr;
        records.source_tag    <= r.source_tag;
        records.final_record  <= fin;
        do
            @(posedge clk);
        while (!records.ready);
        board.note_record(r, fin);
        records_sent++;
        @(negedge clk);
    endtask

    function automatic rec_t make_record(int lo, int hi, int pos);
        rec_t r;
        r.strength      = 8'($urandom_range(hi - lo) + lo);
        r.channel_no    = 8'($urandom);
        r.security_kind = 8'($urandom);
        r.station_addr  = 48'({$urandom, $urandom});
        r.source_tag    = 6'(pos);
        return r;
    endfunction

    task automatic send_set(input int count, input int lo, input int hi);
        for (int i = 0; i < count; i++)
            send_record(make_record(lo, hi, i), i == count - 1);
    endtask

    task automatic send_directed();
        logic [7:0] keys[10];
        keys = '{8'd0, 8'd5, 8'd0, 8'hff, 8'h7f, 8'h80, 8'd0, 8'd5, 8'h80, 8'h7f};
        send_record('{8'h80, 8'h00, 8'h00, 48'h0, 6'h00}, 1'b1);
        send_record('{8'h7f, 8'hff, 8'hff, 48'hffff_ffff_ffff, 6'h3f}, 1'b1);
        for (int i = 0; i < 10; i++)
            send_record('{keys[i], (i % 2) ? 8'h55 : 8'haa, 8'(i), 48'h0123_4567_89a0 + i,
                          6'(i)}, i == 9);
        for (int i = 0; i < 6; i++)
            send_record('{8'hd8, 8'(8 * i), 8'hc3, {16'(i), 32'hdead_beef}, 6'(40 + i)},
                        i == 5);
    endtask

    task automatic send_random();
        int start;
        int sets;
        int mid;
        start = records_sent;
        sets  = 0;
        while (records_sent - start < 135)
        begin
            if (sets == 2)
                send_set(72, -3, 3);
            else if ($urandom_range(1))
                send_set($urandom_range(1, 12), -128, 127);
            else
            begin
                mid = $urandom_range(250) - 125;
                send_set($urandom_range(1, 12), mid - 3, mid + 3);
            end
            sets++;
        end
    endtask

    initial
    begin
        int waited;
        board                 = new();
        records_sent          = 0;
        hold_done             = 1'b0;
        rst_n                 = 1'b0;
        records.valid         = 1'b0;
        records.strength      = '0;
        records.channel_no    = '0;
        records.security_kind = '0;
        records.station_addr  = '0;
        records.source_tag    = '0;
        records.final_record  = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_directed();
        send_random();
        records.valid <= 1'b0;
        waited = 0;
        while (board.pending.size() > 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (board.pending.size() > 0)
        begin
            $error("%0d expected transactions never arrived", board.pending.size());
            board.errors++;
        end
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        bit calm;
        sorted.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            calm = (board != null && board.results_seen >= 90 && board.results_seen < 140);
            if (!hold_done && board != null && board.results_seen >= 30)
            begin
                sorted.ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (rst_n)
                sorted.ready <= calm || $urandom_range(99) >= 13;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sorted.valid && sorted.ready)
            board.check_result('{sorted.out_strength, sorted.out_channel_no,
                                 sorted.out_security_kind, sorted.out_station_addr,
                                 sorted.out_source_tag}, sorted.out_last);
    end

endmodule
